// ===== hdl/tlt_pkg.sv =====
package tlt_pkg;

  // output field width, used by the port list
  localparam int unsigned FIELD_BITS = 16;

  // result records held between scanner and output
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // most records one byte can raise
  localparam int unsigned MAX_RES = 3;

  // token kinds
  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_SEMI    = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_OFFSET  = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_TIME    = 3'd5;
  localparam logic [2:0] KIND_DATE    = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [2:0]            kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
    logic [FIELD_BITS-1:0] line;
    logic                  last;
  } token_rec_t;

  // records raised by one byte, rec[0] first
  typedef struct packed {
    token_rec_t [MAX_RES-1:0] rec;
    logic [1:0]               count;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_eol(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// ===== hdl/tlt_scan.sv =====
module tlt_scan #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned ROW_BITS      = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  output tlt_pkg::scan_res_t  res_o
);
  import tlt_pkg::*;

  localparam logic [3:0] MODE_IDLE        = 4'd0;
  localparam logic [3:0] MODE_SLASH       = 4'd1;
  localparam logic [3:0] MODE_COMMENT     = 4'd2;
  localparam logic [3:0] MODE_IDENT       = 4'd3;
  localparam logic [3:0] MODE_NUMBER      = 4'd4;
  localparam logic [3:0] MODE_STRING      = 4'd5;
  localparam logic [3:0] MODE_OFFSET      = 4'd6;
  localparam logic [3:0] MODE_OFS_SLASH   = 4'd7;
  localparam logic [3:0] MODE_OFS_COMMENT = 4'd8;

  localparam logic [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic [ROW_BITS-1:0]      ROW_ONE  = ROW_BITS'(1);

  logic [3:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [ROW_BITS-1:0]      line_q, line_d;
  logic [POSITION_BITS-1:0] tstart_q, tstart_d;
  logic [ROW_BITS-1:0]      tline_q, tline_d;
  logic                     cr_q, cr_d;
  logic                     date_q, date_d;
  logic                     odig_q, odig_d;
  logic [POSITION_BITS-1:0] slash_q, slash_d;

  logic                     do_idle;
  logic                     end_seen;
  logic [1:0]               n_v;
  token_rec_t [MAX_RES-1:0] rec_v;

  function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [POSITION_BITS-1:0] v);
    return (&v) ? v : v + POSITION_BITS'(1);
  endfunction

  function automatic logic [ROW_BITS-1:0] sat_row(input logic [ROW_BITS-1:0] v);
    return (&v) ? v : v + ROW_BITS'(1);
  endfunction

  function automatic logic [FIELD_BITS-1:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+FIELD_BITS-1:0] ext;
    ext = '0;
    ext[POSITION_BITS-1:0] = v;
    return (|ext[POSITION_BITS+FIELD_BITS-1:FIELD_BITS]) ? '1 : ext[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] clamp_row(input logic [ROW_BITS-1:0] v);
    logic [ROW_BITS+FIELD_BITS-1:0] ext;
    ext = '0;
    ext[ROW_BITS-1:0] = v;
    return (|ext[ROW_BITS+FIELD_BITS-1:FIELD_BITS]) ? '1 : ext[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] span(input logic [POSITION_BITS-1:0] from,
                                                 input logic [POSITION_BITS-1:0] upto);
    return clamp_pos((upto >= from) ? upto - from : POS_ZERO);
  endfunction

  function automatic token_rec_t make_rec(input logic [2:0]            kind,
                                          input logic [FIELD_BITS-1:0] start,
                                          input logic [FIELD_BITS-1:0] len,
                                          input logic [FIELD_BITS-1:0] line);
    token_rec_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.last  = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    line_d   = line_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    cr_d     = 1'b0;
    date_d   = date_q;
    odig_d   = odig_q;
    slash_d  = slash_q;
    do_idle  = 1'b0;
    end_seen = 1'b0;
    n_v      = 2'd0;
    rec_v    = '0;

    unique case (mode_q)
      MODE_SLASH: begin
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          rec_v[n_v] = make_rec(KIND_UNKNOWN, clamp_pos(slash_q), '0, clamp_row(line_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if ((byte_i == CH_NUL) || is_eol(byte_i)) begin
          do_idle = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!(is_letter(byte_i) || is_digit(byte_i) || (byte_i == CH_UNDER))) begin
          rec_v[n_v] = make_rec(KIND_IDENT, clamp_pos(tstart_q), span(tstart_q, pos_q),
                                clamp_row(tline_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if ((byte_i == CH_MINUS) || (byte_i == CH_DOT)) begin
          date_d = 1'b1;
        end else if (!(is_digit(byte_i) || (byte_i == CH_COLON))) begin
          rec_v[n_v] = make_rec(date_q ? KIND_DATE : KIND_TIME, clamp_pos(tstart_q),
                                span(tstart_q, pos_q), clamp_row(tline_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if ((byte_i == CH_QUOTE) || (byte_i == CH_NUL)) begin
          rec_v[n_v] = make_rec(KIND_STRING, clamp_pos(tstart_q), span(tstart_q, pos_q),
                                clamp_row(tline_q));
          n_v = n_v + 2'd1;
          if (byte_i == CH_QUOTE) begin
            mode_d = MODE_IDLE;
          end else begin
            do_idle = 1'b1;
          end
        end
      end
      MODE_OFFSET: begin
        priority if (is_digit(byte_i)) begin
          odig_d = 1'b1;
        end else if (!odig_q && is_blank(byte_i)) begin
          mode_d = MODE_OFFSET;
        end else if (!odig_q && is_eol(byte_i)) begin
          if (!((byte_i == CH_LF) && cr_q)) begin
            cr_d   = (byte_i == CH_CR);
            line_d = sat_row(line_q);
          end
        end else if (!odig_q && (byte_i == CH_SLASH)) begin
          slash_d = pos_q;
          mode_d  = MODE_OFS_SLASH;
        end else begin
          rec_v[n_v] = make_rec(KIND_OFFSET, clamp_pos(tstart_q), span(tstart_q, pos_q),
                                clamp_row(tline_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_OFS_SLASH: begin
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_OFS_COMMENT;
        end else begin
          // offset closes at the slash, then the slash is an unknown token
          rec_v[n_v] = make_rec(KIND_OFFSET, clamp_pos(tstart_q), span(tstart_q, slash_q),
                                clamp_row(tline_q));
          n_v = n_v + 2'd1;
          rec_v[n_v] = make_rec(KIND_UNKNOWN, clamp_pos(slash_q), '0, clamp_row(line_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_OFS_COMMENT: begin
        if (is_eol(byte_i)) begin
          if (!((byte_i == CH_LF) && cr_q)) begin
            cr_d   = (byte_i == CH_CR);
            line_d = sat_row(line_q);
          end
          mode_d = MODE_OFFSET;
        end else if (byte_i == CH_NUL) begin
          rec_v[n_v] = make_rec(KIND_OFFSET, clamp_pos(tstart_q), span(tstart_q, pos_q),
                                clamp_row(tline_q));
          n_v = n_v + 2'd1;
          do_idle = 1'b1;
        end
      end
      default: begin
        // idle, and any code without meaning
        do_idle = 1'b1;
      end
    endcase

    // byte handled as a fresh byte between tokens
    if (do_idle) begin
      mode_d = MODE_IDLE;
      priority if (byte_i == CH_NUL) begin
        rec_v[n_v] = make_rec(KIND_END, clamp_pos(pos_q), '0, clamp_row(line_q));
        n_v = n_v + 2'd1;
        end_seen = 1'b1;
      end else if (is_blank(byte_i)) begin
        mode_d = MODE_IDLE;
      end else if (is_eol(byte_i)) begin
        if (!((byte_i == CH_LF) && cr_q)) begin
          cr_d   = (byte_i == CH_CR);
          line_d = sat_row(line_q);
        end
      end else if (byte_i == CH_SLASH) begin
        slash_d = pos_q;
        mode_d  = MODE_SLASH;
      end else if (byte_i == CH_SEMI) begin
        rec_v[n_v] = make_rec(KIND_SEMI, clamp_pos(pos_q), '0, clamp_row(line_q));
        n_v = n_v + 2'd1;
      end else if (byte_i == CH_QUOTE) begin
        tstart_d = sat_pos(pos_q);
        tline_d  = line_q;
        mode_d   = MODE_STRING;
      end else if ((byte_i == CH_MINUS) || (byte_i == CH_PLUS)) begin
        tstart_d = pos_q;
        tline_d  = line_q;
        odig_d   = 1'b0;
        mode_d   = MODE_OFFSET;
      end else if (is_letter(byte_i)) begin
        tstart_d = pos_q;
        tline_d  = line_q;
        mode_d   = MODE_IDENT;
      end else if (is_digit(byte_i)) begin
        tstart_d = pos_q;
        tline_d  = line_q;
        date_d   = 1'b0;
        mode_d   = MODE_NUMBER;
      end else begin
        rec_v[n_v] = make_rec(KIND_UNKNOWN, clamp_pos(pos_q), '0, clamp_row(line_q));
        n_v = n_v + 2'd1;
      end
    end

    // end of text returns everything to the reset values
    if (end_seen) begin
      mode_d   = MODE_IDLE;
      pos_d    = POS_ZERO;
      line_d   = ROW_ONE;
      tstart_d = POS_ZERO;
      tline_d  = ROW_ONE;
      cr_d     = 1'b0;
      date_d   = 1'b0;
      odig_d   = 1'b0;
      slash_d  = POS_ZERO;
    end else begin
      pos_d = sat_pos(pos_q);
    end

    if (n_v != 2'd0) begin
      rec_v[n_v - 2'd1].last = 1'b1;
    end
  end

  assign res_o.rec   = rec_v;
  assign res_o.count = n_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= POS_ZERO;
      line_q   <= ROW_ONE;
      tstart_q <= POS_ZERO;
      tline_q  <= ROW_ONE;
      cr_q     <= 1'b0;
      date_q   <= 1'b0;
      odig_q   <= 1'b0;
      slash_q  <= POS_ZERO;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      cr_q     <= cr_d;
      date_q   <= date_d;
      odig_q   <= odig_d;
      slash_q  <= slash_d;
    end
  end

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (byte_i == CH_NUL)) |=>
      ((mode_q == MODE_IDLE) && (pos_q == POS_ZERO) && (line_q == ROW_ONE)))
    else $error("end of text did not restart the scanner");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_i == CH_NUL) |-> (n_v != 2'd0))
    else $error("end of text raised no token");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q != '0) && (tline_q != '0))
    else $error("line counter reached zero");

endmodule

// ===== hdl/tlt_rqueue.sv =====
module tlt_rqueue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tlt_pkg::scan_res_t  res_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                room_o,
  output tlt_pkg::token_rec_t head_o
);
  import tlt_pkg::*;

  token_rec_t [QUEUE_DEPTH-1:0] q_q, q_d;
  logic [QCNT_BITS-1:0]         count_q, count_d;
  logic [QCNT_BITS-1:0]         avail;
  logic [QCNT_BITS-1:0]         n_push;
  logic [QCNT_BITS-1:0]         src;
  logic [QCNT_BITS-1:0]         k;

  // what survives the pop, plus the records of the byte taken
  assign avail   = count_q - QCNT_BITS'(pop_i);
  assign n_push  = push_i ? QCNT_BITS'(res_i.count) : '0;
  assign count_d = avail + n_push;

  always_comb begin
    q_d = q_q;
    src = '0;
    k   = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      src = QCNT_BITS'(j) + QCNT_BITS'(pop_i);
      k   = QCNT_BITS'(j) - avail;
      if (QCNT_BITS'(j) < avail) begin
        q_d[j] = q_q[src[1:0]];
      end else if (k < n_push) begin
        q_d[j] = res_i.rec[k[1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // room for the most records one byte can raise
  assign room_o  = (count_q <= QCNT_BITS'(QUEUE_DEPTH - MAX_RES));
  assign valid_o = (count_q != '0);
  assign head_o  = q_q[0];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ((4'(count_q) + 4'(res_i.count)) <= 4'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty result queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (count_q == $past(count_q) - QCNT_BITS'(1)))
    else $error("result queue count lost track");

endmodule

// ===== hdl/time_log_tokenizer_unit.sv =====
// Time log tokenizer.
// Input channel: one text byte per word on text_byte_i, qualified by
// in_valid_i; the unit holds it off with in_stall_o. Byte 0 ends the text.
// Output channel: one token record per word (kind, start position, length,
// starting line, last_of_run), qualified by out_valid_o and held by the
// receiver through out_stall_i. last_of_run marks the final record that a
// byte produced; a byte may give zero, one, two or three records.
// A record enters the registered result queue when its byte is taken and
// reaches the output once the records ahead of it have gone. Throughput:
// one byte per cycle while bytes give at most one record each and the
// receiver keeps up. Records beyond that pile up, so the input stalls until
// the four-entry result queue drains to at most one record (depth minus MAX_RES).
// A stalled receiver leaves the queued records in place; the input then
// stalls once more than one record waits.
// Reset: position 0, line 1, scanner idle, queue empty. No clearing pass.
// Byte 0 also returns the scanner to these values after its end record.
module time_log_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned ROW_BITS      = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       text_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       token_kind_o,
  output logic [tlt_pkg::FIELD_BITS-1:0]   start_position_o,
  output logic [tlt_pkg::FIELD_BITS-1:0]   text_length_o,
  output logic [tlt_pkg::FIELD_BITS-1:0]   line_number_o,
  output logic                             last_of_run_o
);
  import tlt_pkg::*;

  logic       in_accept;
  logic       out_pop;
  logic       room;
  scan_res_t  scan_res;
  token_rec_t head;

  // a byte is taken only when the queue can hold all it may raise
  assign in_stall_o = !room;
  assign in_accept  = in_valid_i && room;
  assign out_pop    = out_valid_o && !out_stall_i;

  tlt_scan #(
    .POSITION_BITS(POSITION_BITS),
    .ROW_BITS     (ROW_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .byte_i  (text_byte_i),
    .res_o   (scan_res)
  );

  // registered result queue, head drives the output word
  tlt_rqueue u_rqueue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_accept),
    .res_i  (scan_res),
    .pop_i  (out_pop),
    .valid_o(out_valid_o),
    .room_o (room),
    .head_o (head)
  );

  assign token_kind_o     = head.kind;
  assign start_position_o = head.start;
  assign text_length_o    = head.len;
  assign line_number_o    = head.line;
  assign last_of_run_o    = head.last;

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // ceiling for a row or a position: 2^16 - 1
  localparam logic [15:0] SAT_TOP = 16'hFFFF;

  // scanner modes held by the predictor
  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_SLASH,
    SCAN_COMMENT,
    SCAN_IDENT,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_OFFSET,
    SCAN_OFS_SLASH,
    SCAN_OFS_COMMENT
  } scan_mode_e;

  // one text byte waiting to go out, with the gap the sender leaves after it
  typedef struct {
    logic [7:0]  data;
    int unsigned pause;
  } text_word_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       byte_valid = 1'b0;
  logic [7:0] byte_data  = 8'h00;
  logic       rcv_stall  = 1'b0;

  logic        in_stall;
  logic        tok_valid;
  logic [2:0]  tok_kind;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] tok_line;
  logic        tok_last;

  time_log_tokenizer_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (byte_valid),
    .in_stall_o       (in_stall),
    .text_byte_i      (byte_data),
    .out_valid_o      (tok_valid),
    .out_stall_i      (rcv_stall),
    .token_kind_o     (tok_kind),
    .start_position_o (tok_start),
    .text_length_o    (tok_len),
    .line_number_o    (tok_line),
    .last_of_run_o    (tok_last)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Token predictor: its own copy of the scanner state
  // ---------------------------------------------------------------------
  scan_mode_e  scan_state;
  logic [15:0] text_pos;      // position of the next byte
  logic [15:0] text_row;      // current line, from 1
  logic [15:0] tok_from;      // start of the open token
  logic [15:0] tok_row;       // line at the open token
  logic        cr_pending;    // last byte was a CR that bumped the row
  logic        dash_seen;     // number holds '-' or '.', so it is a date
  logic        sign_digits;   // offset has reached its digits
  logic [15:0] slash_pos;     // where a possible comment opener stood
  logic        text_ended;

  token_rec_t byte_tokens[$];     // records raised by the byte in hand
  token_rec_t expected_tokens[$]; // records still owed by the unit

  int unsigned mismatches  = 0;
  int unsigned tokens_seen = 0;
  int unsigned cycles      = 0;

  function automatic logic num_char(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic alpha_char(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic blank_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic logic eol_char(input logic [7:0] b);
    return b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == SAT_TOP) ? v : v + 16'd1;
  endfunction

  // lengths are taken between saturated positions, never negative
  function automatic logic [15:0] span_len(input logic [15:0] from, input logic [15:0] upto);
    return (upto >= from) ? upto - from : 16'd0;
  endfunction

  function automatic void reset_scanner();
    scan_state  = SCAN_IDLE;
    text_pos    = 16'd0;
    text_row    = 16'd1;
    tok_from    = 16'd0;
    tok_row     = 16'd1;
    cr_pending  = 1'b0;
    dash_seen   = 1'b0;
    sign_digits = 1'b0;
    slash_pos   = 16'd0;
  endfunction

  function automatic void add_token(input logic [2:0] k, input logic [15:0] s,
                                    input logic [15:0] l, input logic [15:0] r);
    token_rec_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = r;
    t.last  = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  // CR LF is one line break; a lone CR or LF is one each
  function automatic void new_line(input logic [7:0] b, input logic cr_prev);
    if (b == CH_LF && cr_prev) return;
    if (b == CH_CR) cr_pending = 1'b1;
    text_row = bump(text_row);
  endfunction

  // byte seen with no token open
  function automatic void between_tokens(input logic [7:0] b, input logic [15:0] at,
                                         input logic cr_prev);
    scan_state = SCAN_IDLE;
    if (b == CH_NUL) begin
      add_token(KIND_END, at, 16'd0, text_row);
      text_ended = 1'b1;
    end else if (blank_char(b)) begin
      // skipped
    end else if (eol_char(b)) begin
      new_line(b, cr_prev);
    end else if (b == CH_SLASH) begin
      slash_pos  = at;
      scan_state = SCAN_SLASH;
    end else if (b == CH_SEMI) begin
      add_token(KIND_SEMI, at, 16'd0, text_row);
    end else if (b == CH_QUOTE) begin
      tok_from   = bump(at);
      tok_row    = text_row;
      scan_state = SCAN_STRING;
    end else if (b == CH_MINUS || b == CH_PLUS) begin
      tok_from    = at;
      tok_row     = text_row;
      sign_digits = 1'b0;
      scan_state  = SCAN_OFFSET;
    end else if (alpha_char(b)) begin
      tok_from   = at;
      tok_row    = text_row;
      scan_state = SCAN_IDENT;
    end else if (num_char(b)) begin
      tok_from   = at;
      tok_row    = text_row;
      dash_seen  = 1'b0;
      scan_state = SCAN_NUMBER;
    end else begin
      add_token(KIND_UNKNOWN, at, 16'd0, text_row);
    end
  endfunction

  // works out the records one accepted byte raises and queues them
  function automatic void scan_byte(input logic [7:0] b);
    logic [15:0] at;
    logic        cr_prev;
    at         = text_pos;
    cr_prev    = cr_pending;
    cr_pending = 1'b0;
    text_ended = 1'b0;
    byte_tokens.delete();
    case (scan_state)
      SCAN_SLASH: begin
        if (b == CH_SLASH) scan_state = SCAN_COMMENT;
        else begin
          add_token(KIND_UNKNOWN, slash_pos, 16'd0, text_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_COMMENT: begin
        if (b == CH_NUL || eol_char(b)) between_tokens(b, at, cr_prev);
      end
      SCAN_IDENT: begin
        if (!(alpha_char(b) || num_char(b) || b == CH_UNDER)) begin
          add_token(KIND_IDENT, tok_from, span_len(tok_from, at), tok_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_NUMBER: begin
        if (b == CH_MINUS || b == CH_DOT) dash_seen = 1'b1;
        else if (!(num_char(b) || b == CH_COLON)) begin
          add_token(dash_seen ? KIND_DATE : KIND_TIME, tok_from,
                    span_len(tok_from, at), tok_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_STRING: begin
        if (b == CH_QUOTE) begin
          add_token(KIND_STRING, tok_from, span_len(tok_from, at), tok_row);
          scan_state = SCAN_IDLE;
        end else if (b == CH_NUL) begin
          add_token(KIND_STRING, tok_from, span_len(tok_from, at), tok_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_OFFSET: begin
        if (num_char(b)) sign_digits = 1'b1;
        else if (!sign_digits && blank_char(b)) begin
          // whitespace between sign and digits
        end else if (!sign_digits && eol_char(b)) new_line(b, cr_prev);
        else if (!sign_digits && b == CH_SLASH) begin
          slash_pos  = at;
          scan_state = SCAN_OFS_SLASH;
        end else begin
          add_token(KIND_OFFSET, tok_from, span_len(tok_from, at), tok_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_OFS_SLASH: begin
        if (b == CH_SLASH) scan_state = SCAN_OFS_COMMENT;
        else begin
          // lone slash in offset whitespace ends the offset at the slash
          add_token(KIND_OFFSET, tok_from, span_len(tok_from, slash_pos), tok_row);
          add_token(KIND_UNKNOWN, slash_pos, 16'd0, text_row);
          between_tokens(b, at, cr_prev);
        end
      end
      SCAN_OFS_COMMENT: begin
        if (eol_char(b)) begin
          new_line(b, cr_prev);
          scan_state = SCAN_OFFSET;
        end else if (b == CH_NUL) begin
          add_token(KIND_OFFSET, tok_from, span_len(tok_from, at), tok_row);
          between_tokens(b, at, cr_prev);
        end
      end
      default: between_tokens(b, at, cr_prev);
    endcase
    if (text_ended) reset_scanner();
    else text_pos = bump(at);
    if (byte_tokens.size() != 0) byte_tokens[$].last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Text source: queue of bytes filled up front, gap drawn per byte
  // ---------------------------------------------------------------------
  text_word_t text_queue[$];
  logic       calm = 1'b0;   // set for stretches with no sender gaps

  task automatic put_byte(input logic [7:0] b);
    text_word_t w;
    w.data  = b;
    w.pause = calm ? 0 : $urandom_range(0, 3);
    text_queue.push_back(w);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_odd_byte();
    string odd;
    odd = "!#$%&'()*,<=>?@[]^`{|}~";
    return $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                : odd[$urandom_range(0, odd.len() - 1)];
  endfunction

  task automatic put_line_end();
    case ($urandom_range(0, 2))
      0: begin put_byte(CH_CR); put_byte(CH_LF); end
      1: put_byte(CH_CR);
      default: put_byte(CH_LF);
    endcase
  endtask

  task automatic put_comment();
    put_byte(CH_SLASH);
    put_byte(CH_SLASH);
    repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(32, 126)));
    put_line_end();
  endtask

  // one well formed lexeme with random content, or some noise
  task automatic put_fragment();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0, 1: begin
        put_byte(rand_letter());
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 2))
            0: put_byte(rand_letter());
            1: put_byte(8'($urandom_range(48, 57)));
            default: put_byte(CH_UNDER);
          endcase
        end
      end
      2, 3: begin
        put_byte(8'($urandom_range(48, 57)));
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: put_byte(CH_COLON);
            1: put_byte(CH_MINUS);
            2: put_byte(CH_DOT);
            default: put_byte(8'($urandom_range(48, 57)));
          endcase
        end
      end
      4: begin
        // string, CR and LF inside it included, now and then unterminated
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(1, 255));
          put_byte(c == CH_QUOTE ? CH_LF : c);
        end
        if ($urandom_range(0, 9) != 0) put_byte(CH_QUOTE);
      end
      5, 6: begin
        // signed offset with whitespace, breaks and comments before digits
        put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: put_byte(CH_SPACE);
            1: put_byte(CH_TAB);
            2: put_line_end();
            default: put_comment();
          endcase
        end
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(48, 57)));
      end
      7: put_byte(CH_SEMI);
      8: repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      9: put_line_end();
      10: put_comment();
      11: begin
        // lone slash, sometimes straight after a sign
        if ($urandom_range(0, 1)) put_byte(CH_MINUS);
        put_byte(CH_SLASH);
        put_byte($urandom_range(0, 1) ? CH_SEMI : rand_odd_byte());
      end
      12: put_byte(rand_odd_byte());
      13: put_byte(8'($urandom_range(1, 255)));
      14: begin
        // unfinished comment or offset comment, now and then cut by the end of text
        if ($urandom_range(0, 1)) put_byte(CH_PLUS);
        put_byte(CH_SLASH);
        put_byte(CH_SLASH);
        put_byte(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 2) == 0) put_byte(CH_NUL);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) put_byte(CH_NUL);
        else put_byte(CH_SPACE);
      end
    endcase
    if ($urandom_range(0, 1)) put_byte(CH_SPACE);
  endtask

  // ---------------------------------------------------------------------
  // Sender: offers the next byte, after the drawn gap, once the previous word is taken
  // ---------------------------------------------------------------------
  text_word_t  next_word;
  int unsigned pause_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      byte_valid <= 1'b0;
      byte_data  <= CH_NUL;
      pause_left <= 0;
    end else begin
      if (byte_valid && !in_stall) scan_byte(byte_data);
      // payload may only move once the current word has gone
      if (!byte_valid || !in_stall) begin
        if (pause_left != 0) begin
          pause_left <= pause_left - 1;
          byte_valid <= 1'b0;
        end else if (text_queue.size() != 0) begin
          next_word = text_queue.pop_front();
          byte_valid <= 1'b1;
          byte_data  <= next_word.data;
          pause_left <= next_word.pause;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: checks each taken record against the oldest prediction.
  // Long hold-offs at set points let the result queue fill and push the
  // unit into stalling its input.
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  token_rec_t  want;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rcv_stall <= 1'b0;
    end else begin
      if (tok_valid && !rcv_stall) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected token: kind %0d start %0d len %0d line %0d last %0d",
                   $time, tok_kind, tok_start, tok_len, tok_line, tok_last);
        end else begin
          want = expected_tokens.pop_front();
          if (tok_kind !== want.kind) begin
            mismatches++;
            $display("%0t: kind: expected %0d, got %0d", $time, want.kind, tok_kind);
          end
          if (tok_start !== want.start) begin
            mismatches++;
            $display("%0t: start: expected %0d, got %0d", $time, want.start, tok_start);
          end
          if (tok_len !== want.len) begin
            mismatches++;
            $display("%0t: length: expected %0d, got %0d", $time, want.len, tok_len);
          end
          if (tok_line !== want.line) begin
            mismatches++;
            $display("%0t: line: expected %0d, got %0d", $time, want.line, tok_line);
          end
          if (tok_last !== want.last) begin
            mismatches++;
            $display("%0t: last: expected %0d, got %0d", $time, want.last, tok_last);
          end
        end
        if (tokens_seen == 30 || tokens_seen == 80) stall_left = 60;
        else if (tokens_seen % 100 < 25) stall_left = 0;  // keep-up stretch
        else stall_left = $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        rcv_stall <= 1'b1;
        stall_left--;
      end else begin
        rcv_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned base;
    reset_scanner();

    // directed: ident with '_', string, CR LF, offset over a comment and
    // a break, lone slash in offset whitespace (three records from ';'),
    // time, date, non-ASCII byte, lone slash then lone CR, end of text
    put_text("a_");
    put_byte(CH_QUOTE);
    put_text("x");
    put_byte(CH_QUOTE);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_text("+ //");
    put_byte(CH_LF);
    put_text("5-/;1:2 3-4");
    put_byte(8'hFF);
    put_byte(CH_SLASH);
    put_byte(CH_CR);
    put_byte(CH_NUL);
    // string left open until the end of text
    put_byte(CH_QUOTE);
    put_text("ab");
    put_byte(CH_NUL);

    // random lexemes, broken pieces and noise
    base = text_queue.size();
    while (text_queue.size() - base < 460) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      put_fragment();
    end
    calm = 1'b0;
    put_byte(CH_NUL);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: sampled on the falling edge, clear of the clocked blocks
    while (text_queue.size() != 0 || byte_valid || expected_tokens.size() != 0)
      @(negedge clk);
    // keep watching for stray records before the verdict
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tlt_pkg.sv
hdl/tlt_scan.sv
hdl/tlt_rqueue.sv
hdl/time_log_tokenizer_unit.sv
dv/tb.sv
